// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the beam logger rtl, clocked on i_clk and
// disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain condition that holds every cycle out of reset
`define PBSSL_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// same-cycle implication
`define PBSSL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pbssl_pkg.sv =====
// ----------------------------------------------------------------------------
// pbssl_pkg
// types, constants and register codes of the per-beam signal strength logger
// ----------------------------------------------------------------------------
package pbssl_pkg;

    localparam int BEAM_COUNT = 128;
    localparam int RING_SLOTS = 12;
    localparam int BEAM_W     = $clog2(BEAM_COUNT);
    localparam int RING_DEPTH = BEAM_COUNT * RING_SLOTS;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int SLOT_W     = 4;
    localparam int BMEM_W     = 64;
    localparam int ADDR_W     = 4;

    localparam logic [15:0] RST_BEACON_TYPE = 16'h000c;
    localparam logic [31:0] RST_INTERVAL    = 32'd15360;
    localparam logic [15:0] RST_CEILING     = 16'd63000;

    typedef enum logic [1:0] {
        REG_BEACON_TYPE = 2'd0,
        REG_INTERVAL    = 2'd1,
        REG_CEILING     = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        OUT_NOT_BEACON = 2'd0,
        OUT_DUPLICATE  = 2'd1,
        OUT_RECORDED   = 2'd2
    } t_outcome;

    typedef struct packed {
        logic [15:0] frame_kind;
        logic [31:0] arrival_time;
        logic [5:0]  sector_number;
        logic        antenna_bit;
        logic [31:0] raw_strength;
    } t_frame;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [6:0]  beam_number;
        logic [3:0]  slot_used;
        logic [27:0] scaled_strength;
        logic        strength_stored;
        logic [31:0] beam_packet_count;
    } t_result;

endpackage

// ===== rtl/pbssl_ram.sv =====
// ----------------------------------------------------------------------------
// pbssl_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module pbssl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/per_beam_signal_strength_logger_unit.sv =====
// ----------------------------------------------------------------------------
// per_beam_signal_strength_logger_unit
// logs beacon timestamps, packet counts and scaled strength per beam
// ----------------------------------------------------------------------------
// usage
// - a frame word is taken at a clock edge with start high and busy low
// - every accepted word gives one result word: o_valid rises at the edge that
//   ends the work state and holds o_result for exactly one cycle
// - one word at a time: the beam memory read is registered at the accepting
//   edge and the read-modify-write of timestamp and count is the work state
// - the ring clear of the next slot is written in the result cycle,
//   alongside the next word's beam read
// - after reset busy stays high while the strength ring and the beam memory
//   are swept to zero; apb writes are taken during the sweep
// - registers over apb: 0x0 beacon type, 0x4 interval gap, 0x8 strength
//   ceiling; pready is always high, a write lands on psel & penable & pwrite
// - the receiver cannot stall, o_valid is a strobe
// - change registers only while the block is idle
// ----------------------------------------------------------------------------
module per_beam_signal_strength_logger_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  pbssl_pkg::t_frame            i_frame,
    output logic                         o_valid,
    output pbssl_pkg::t_result           o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pbssl_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

`include "assert_macros.svh"

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_WORK  = 3'b100
    } t_state;

    localparam int BW  = pbssl_pkg::BEAM_W;
    localparam int RAW = pbssl_pkg::RING_AW;
    localparam int SW  = pbssl_pkg::SLOT_W;

    t_state                  r_state;
    t_state                  n_state;
    logic [RAW-1:0]          r_clr_cnt;
    logic [RAW-1:0]          n_clr_cnt;
    logic                    r_clr_pend;
    logic                    n_clr_pend;
    logic [RAW-1:0]          r_clr_addr;
    logic [RAW-1:0]          n_clr_addr;
    logic [15:0]             r_type_code;
    logic [31:0]             r_interval;
    logic [15:0]             r_ceiling;
    logic [SW-1:0]           r_slot;
    logic [SW-1:0]           n_slot;
    logic [31:0]             r_last_time;
    logic [31:0]             n_last_time;
    pbssl_pkg::t_frame       r_frame;
    logic                    r_valid;
    logic                    n_valid;
    pbssl_pkg::t_result      r_result;
    pbssl_pkg::t_result      n_result;

    logic                    w_accept;
    logic                    w_cfg_wr;
    logic [1:0]              w_cfg_idx;
    logic [BW-1:0]           w_rd_beam;
    logic [BW-1:0]           w_beam;
    logic [pbssl_pkg::BMEM_W-1:0] w_beam_rd;
    logic [31:0]             w_rd_time;
    logic [31:0]             w_rd_count;
    logic                    w_is_beacon;
    logic                    w_dup;
    logic                    w_record;
    logic [31:0]             w_count_inc;
    logic [31:0]             w_gap;
    logic [SW-1:0]           w_slot_adv;
    logic [SW-1:0]           w_slot_next;
    logic [27:0]             w_scaled;
    logic                    w_stored;
    logic [RAW-1:0]          w_ring_base;
    logic                    w_bmem_we;
    logic [BW-1:0]           w_bmem_waddr;
    logic [pbssl_pkg::BMEM_W-1:0] w_bmem_wdata;
    logic                    w_ring_we;
    logic [RAW-1:0]          w_ring_waddr;
    logic [15:0]             w_ring_wdata;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start & ~busy;
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;
    assign w_cfg_idx = paddr[3:2];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_code <= pbssl_pkg::RST_BEACON_TYPE;
            r_interval  <= pbssl_pkg::RST_INTERVAL;
            r_ceiling   <= pbssl_pkg::RST_CEILING;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                pbssl_pkg::REG_BEACON_TYPE: r_type_code <= pwdata[15:0];
                pbssl_pkg::REG_INTERVAL:    r_interval  <= pwdata;
                pbssl_pkg::REG_CEILING:     r_ceiling   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            pbssl_pkg::REG_BEACON_TYPE: prdata = {16'd0, r_type_code};
            pbssl_pkg::REG_INTERVAL:    prdata = r_interval;
            pbssl_pkg::REG_CEILING:     prdata = {16'd0, r_ceiling};
            default:                    prdata = 32'd0;
        endcase
    end

    // beam memory: {last timestamp, packet count}
    assign w_rd_beam = BW'({i_frame.antenna_bit, i_frame.sector_number});
    assign w_beam    = BW'({r_frame.antenna_bit, r_frame.sector_number});

    pbssl_ram #(
        .WIDTH (pbssl_pkg::BMEM_W),
        .DEPTH (pbssl_pkg::BEAM_COUNT)
    ) u_beam_mem (
        .i_clk   (i_clk),
        .i_we    (w_bmem_we),
        .i_waddr (w_bmem_waddr),
        .i_wdata (w_bmem_wdata),
        .i_re    (w_accept),
        .i_raddr (w_rd_beam),
        .o_rdata (w_beam_rd)
    );

    pbssl_ram #(
        .WIDTH (16),
        .DEPTH (pbssl_pkg::RING_DEPTH)
    ) u_ring_mem (
        .i_clk   (i_clk),
        .i_we    (w_ring_we),
        .i_waddr (w_ring_waddr),
        .i_wdata (w_ring_wdata),
        .i_re    (1'b0),
        .i_raddr (r_clr_cnt),
        .o_rdata ()
    );

    // modify stage
    assign w_rd_time   = w_beam_rd[63:32];
    assign w_rd_count  = w_beam_rd[31:0];
    assign w_is_beacon = (r_frame.frame_kind == r_type_code);
    assign w_dup       = (w_rd_time == r_frame.arrival_time);
    assign w_record    = (r_state == ST_WORK) & w_is_beacon & ~w_dup;
    assign w_count_inc = w_rd_count + 32'd1;
    assign w_gap       = r_frame.arrival_time - r_last_time;
    assign w_slot_adv  = (w_gap > r_interval)
                       ? ((r_slot == SW'(pbssl_pkg::RING_SLOTS - 1)) ? '0 : r_slot + SW'(1))
                       : r_slot;
    assign w_slot_next = (w_slot_adv == SW'(pbssl_pkg::RING_SLOTS - 1)) ? '0
                       : w_slot_adv + SW'(1);
    assign w_scaled    = r_frame.raw_strength[31:4];
    assign w_stored    = (w_scaled < {12'd0, r_ceiling});
    assign w_ring_base = RAW'(w_beam) * RAW'(pbssl_pkg::RING_SLOTS);

    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_bmem_we    = (r_clr_cnt < RAW'(pbssl_pkg::BEAM_COUNT));
            w_bmem_waddr = r_clr_cnt[BW-1:0];
            w_bmem_wdata = '0;
        end else begin
            w_bmem_we    = w_record;
            w_bmem_waddr = w_beam;
            w_bmem_wdata = {r_frame.arrival_time, w_count_inc};
        end
    end

    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_ring_we    = 1'b1;
            w_ring_waddr = r_clr_cnt;
            w_ring_wdata = '0;
        end else if (r_clr_pend) begin
            w_ring_we    = 1'b1;
            w_ring_waddr = r_clr_addr;
            w_ring_wdata = '0;
        end else begin
            w_ring_we    = w_record & w_stored;
            w_ring_waddr = w_ring_base + RAW'(w_slot_adv);
            w_ring_wdata = w_scaled[15:0];
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_clr_pend  = 1'b0;
        n_clr_addr  = r_clr_addr;
        n_slot      = r_slot;
        n_last_time = r_last_time;
        n_valid     = 1'b0;
        n_result    = r_result;
        case (r_state)
            ST_CLEAR: begin
                n_clr_cnt = r_clr_cnt + RAW'(1);
                if (r_clr_cnt == RAW'(pbssl_pkg::RING_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_WORK;
                end
            end
            ST_WORK: begin
                n_state  = ST_IDLE;
                n_valid  = 1'b1;
                n_result = '0;
                n_result.beam_number = {r_frame.antenna_bit, r_frame.sector_number};
                if (!w_is_beacon) begin
                    n_result.outcome = pbssl_pkg::OUT_NOT_BEACON;
                end else if (w_dup) begin
                    n_result.outcome           = pbssl_pkg::OUT_DUPLICATE;
                    n_result.beam_packet_count = w_rd_count;
                end else begin
                    n_result.outcome           = pbssl_pkg::OUT_RECORDED;
                    n_result.slot_used         = w_slot_adv;
                    n_result.scaled_strength   = w_scaled;
                    n_result.strength_stored   = w_stored;
                    n_result.beam_packet_count = w_count_inc;
                    n_slot      = w_slot_adv;
                    n_last_time = r_frame.arrival_time;
                    n_clr_pend  = 1'b1;
                    n_clr_addr  = w_ring_base + RAW'(w_slot_next);
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_clr_pend  <= 1'b0;
            r_slot      <= '0;
            r_last_time <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_clr_pend  <= n_clr_pend;
            r_slot      <= n_slot;
            r_last_time <= n_last_time;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_clr_addr <= n_clr_addr;
        r_result   <= n_result;
        if (w_accept) begin
            r_frame <= i_frame;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    `PBSSL_ASSERT_IMPL(a_valid_after_work, o_valid, $past(r_state == ST_WORK), "result without work cycle")
    `PBSSL_ASSERT(a_ring_port_free, !(r_clr_pend && r_state == ST_WORK), "ring write port collision")
    `PBSSL_ASSERT(a_slot_range, r_slot < SW'(pbssl_pkg::RING_SLOTS), "shared slot out of range")
    `PBSSL_ASSERT_IMPL(a_no_accept_in_sweep, r_state == ST_CLEAR, !w_accept, "word taken during clear sweep")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the per-beam signal strength logger: a queue-fed
// frame driver with random start gaps, a result monitor checked against a
// beam timestamp / packet count / slot tracker, and apb register writes
// between phases, several of them at the register extremes
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned    CYCLE_LIMIT     = 400000;
    localparam logic [pbssl_pkg::ADDR_W-1:0] UNUSED_REG_ADDR = 4'hc;

    logic                         i_clk   = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start   = 1'b0;
    logic                         busy;
    pbssl_pkg::t_frame            i_frame = '0;
    logic                         o_valid;
    pbssl_pkg::t_result           o_result;
    logic                         psel    = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite  = 1'b0;
    logic [pbssl_pkg::ADDR_W-1:0] paddr   = '0;
    logic [31:0]                  pwdata  = '0;
    logic [31:0]                  prdata;
    logic                         pready;

    per_beam_signal_strength_logger_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_frame  (i_frame),
        .o_valid  (o_valid),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // register copy and beam tracking state
    logic [15:0]  cfg_beacon_kind = pbssl_pkg::RST_BEACON_TYPE;
    logic [31:0]  cfg_gap         = pbssl_pkg::RST_INTERVAL;
    logic [15:0]  cfg_ceiling     = pbssl_pkg::RST_CEILING;
    logic [31:0]  beam_time  [pbssl_pkg::BEAM_COUNT];
    logic [31:0]  beam_count [pbssl_pkg::BEAM_COUNT];
    logic [3:0]   ring_slot       = '0;
    logic [31:0]  last_beacon     = '0;

    pbssl_pkg::t_frame   frame_backlog [$];
    pbssl_pkg::t_result  pending_results [$];
    int unsigned  sender_idle_pct = 0;
    int unsigned  mismatches      = 0;
    int unsigned  cycle_count     = 0;

    // stimulus-side view of time and per-beam timestamps
    logic [31:0]  gen_clock = '0;
    logic [31:0]  gen_last_time [pbssl_pkg::BEAM_COUNT];

    task automatic log_frame(input pbssl_pkg::t_frame f);
        pbssl_pkg::t_result r;
        logic [6:0]  beam;
        beam          = {f.antenna_bit, f.sector_number};
        r             = '0;
        r.beam_number = beam;
        if (f.frame_kind != cfg_beacon_kind) begin
            r.outcome = pbssl_pkg::OUT_NOT_BEACON;
        end else if (beam_time[beam] == f.arrival_time) begin
            r.outcome           = pbssl_pkg::OUT_DUPLICATE;
            r.beam_packet_count = beam_count[beam];
        end else begin
            beam_time[beam]  = f.arrival_time;
            beam_count[beam] = beam_count[beam] + 32'd1;
            if (f.arrival_time - last_beacon > cfg_gap) begin
                ring_slot = (ring_slot == 4'(pbssl_pkg::RING_SLOTS - 1)) ? 4'd0
                          : ring_slot + 4'd1;
            end
            last_beacon         = f.arrival_time;
            r.outcome           = pbssl_pkg::OUT_RECORDED;
            r.slot_used         = ring_slot;
            r.scaled_strength   = f.raw_strength[31:4];
            r.strength_stored   = (f.raw_strength[31:4] < cfg_ceiling);
            r.beam_packet_count = beam_count[beam];
        end
        pending_results.push_back(r);
    endtask

    // frame driver
    always @(posedge i_clk) begin : frame_driver
        logic hold;
        hold = start && busy;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                log_frame(i_frame);
            end
            if (!hold) begin
                if (frame_backlog.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    start   <= 1'b1;
                    i_frame <= frame_backlog.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic report(input string field, input logic [31:0] exp_v,
                          input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, field, exp_v, act_v);
        end
    endtask

    // result monitor
    always @(posedge i_clk) begin : result_monitor
        pbssl_pkg::t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result word expected none actual %h",
                         $time, o_result);
            end else begin
                want = pending_results.pop_front();
                report("outcome", 32'(want.outcome), 32'(o_result.outcome));
                report("beam_number", 32'(want.beam_number), 32'(o_result.beam_number));
                report("slot_used", 32'(want.slot_used), 32'(o_result.slot_used));
                report("scaled_strength", 32'(want.scaled_strength),
                       32'(o_result.scaled_strength));
                report("strength_stored", 32'(want.strength_stored),
                       32'(o_result.strength_stored));
                report("beam_packet_count", want.beam_packet_count,
                       o_result.beam_packet_count);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("per_beam_signal_strength_logger_unit test failed");
            $finish;
        end
    end

    function automatic pbssl_pkg::t_frame make_frame(input logic [15:0] kind,
                                                     input logic [31:0] ts,
                                                     input logic [6:0] beam,
                                                     input logic [31:0] raw);
        pbssl_pkg::t_frame f;
        f.frame_kind    = kind;
        f.arrival_time  = ts;
        f.sector_number = beam[5:0];
        f.antenna_bit   = beam[6];
        f.raw_strength  = raw;
        return f;
    endfunction

    task automatic apb_write(input logic [pbssl_pkg::ADDR_W-1:0] addr,
                             input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr[3:2])
            pbssl_pkg::REG_BEACON_TYPE: cfg_beacon_kind = val[15:0];
            pbssl_pkg::REG_INTERVAL:    cfg_gap         = val;
            pbssl_pkg::REG_CEILING:     cfg_ceiling     = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] kind, input logic [31:0] gap,
                              input logic [15:0] ceiling);
        apb_write({pbssl_pkg::REG_BEACON_TYPE, 2'b00}, {16'd0, kind});
        apb_write({pbssl_pkg::REG_INTERVAL, 2'b00}, gap);
        apb_write({pbssl_pkg::REG_CEILING, 2'b00}, {16'd0, ceiling});
    endtask

    task automatic wait_idle();
        while (frame_backlog.size() != 0 || start || pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        // ring clear lands at the end of the result cycle
        repeat (6) @(posedge i_clk);
    endtask

    task automatic add_random_frames(input int unsigned count);
        pbssl_pkg::t_frame f;
        logic [6:0]  beam;
        logic [31:0] step;
        int unsigned pick;
        for (int unsigned n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                f.frame_kind = cfg_beacon_kind;
            end else if (pick < 88) begin
                f.frame_kind = cfg_beacon_kind ^ (16'h1 << $urandom_range(15));
            end else begin
                f.frame_kind = 16'($urandom());
            end
            // mostly a few busy beams so duplicates and counts build up
            if ($urandom_range(99) < 60) begin
                beam = {1'($urandom()), 3'd0, 3'($urandom())};
            end else begin
                beam = 7'($urandom());
            end
            pick = $urandom_range(99);
            if (pick < 15) begin
                f.arrival_time = gen_last_time[beam];
            end else if (pick < 22) begin
                f.arrival_time = $urandom();
            end else begin
                case ($urandom_range(3))
                    0: step = $urandom_range(64);
                    1: step = cfg_gap;
                    2: step = cfg_gap + 32'd1;
                    default: step = $urandom();
                endcase
                f.arrival_time = gen_clock + step;
            end
            f.sector_number = beam[5:0];
            f.antenna_bit   = beam[6];
            case ($urandom_range(3))
                0: f.raw_strength = {12'd0, cfg_ceiling - 16'd1, 4'($urandom())};
                1: f.raw_strength = {12'd0, cfg_ceiling, 4'($urandom())};
                2: f.raw_strength = $urandom_range(32'hfffff);
                default: f.raw_strength = $urandom();
            endcase
            if (f.frame_kind == cfg_beacon_kind) begin
                gen_clock           = f.arrival_time;
                gen_last_time[beam] = f.arrival_time;
            end
            frame_backlog.push_back(f);
        end
    endtask

    initial begin
        foreach (beam_time[i]) begin
            beam_time[i]     = '0;
            beam_count[i]    = '0;
            gen_last_time[i] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames on reset registers
        frame_backlog.push_back(make_frame(16'h0000, 32'd0, 7'd0, 32'd0));
        frame_backlog.push_back(make_frame(16'hffff, 32'hffffffff, 7'd127, 32'hffffffff));
        // zero timestamp on an untouched beam reads as a repeat
        frame_backlog.push_back(make_frame(pbssl_pkg::RST_BEACON_TYPE, 32'd0, 7'd5,
                                           32'h100));
        frame_backlog.push_back(make_frame(pbssl_pkg::RST_BEACON_TYPE, 32'd100, 7'd5,
                                           32'd0));
        frame_backlog.push_back(make_frame(pbssl_pkg::RST_BEACON_TYPE, 32'd100, 7'd5,
                                           32'h55));
        frame_backlog.push_back(make_frame(pbssl_pkg::RST_BEACON_TYPE, 32'd20000, 7'd127,
                                           32'hffffffff));
        frame_backlog.push_back(make_frame(pbssl_pkg::RST_BEACON_TYPE, 32'd35360, 7'd64,
                                           32'd63000 * 32'd16 - 32'd1));
        frame_backlog.push_back(make_frame(pbssl_pkg::RST_BEACON_TYPE, 32'd50721, 7'd63,
                                           32'd63000 * 32'd16));
        // time going backwards is a huge gap
        frame_backlog.push_back(make_frame(pbssl_pkg::RST_BEACON_TYPE, 32'd35360, 7'd5,
                                           32'hf));
        frame_backlog.push_back(make_frame(pbssl_pkg::RST_BEACON_TYPE ^ 16'h1, 32'd50000,
                                           7'd5, 32'd0));
        frame_backlog.push_back(make_frame(pbssl_pkg::RST_BEACON_TYPE, 32'hffffff00, 7'd0,
                                           32'h12345678));
        // gap across the timestamp wrap is small
        frame_backlog.push_back(make_frame(pbssl_pkg::RST_BEACON_TYPE, 32'h00000010, 7'd1,
                                           32'h0000ffff));
        frame_backlog.push_back(make_frame(pbssl_pkg::RST_BEACON_TYPE, 32'h00000010, 7'd1,
                                           32'd0));
        frame_backlog.push_back(make_frame(pbssl_pkg::RST_BEACON_TYPE, 32'h00000011, 7'd1,
                                           32'habcdef01));
        frame_backlog.push_back(make_frame(pbssl_pkg::RST_BEACON_TYPE, 32'haaaaaaaa, 7'h55,
                                           32'haaaaaaaa));
        frame_backlog.push_back(make_frame(pbssl_pkg::RST_BEACON_TYPE, 32'h55555555, 7'h2a,
                                           32'h55555555));
        frame_backlog.push_back(make_frame(16'h5555, 32'h55555555, 7'h2a, 32'h5555aaaa));
        wait_idle();

        apb_write(UNUSED_REG_ADDR, 32'hffffffff);
        set_config(16'h0000, 32'd0, 16'hffff);
        sender_idle_pct = 0;
        add_random_frames(210);
        wait_idle();

        set_config(16'hffff, 32'hffffffff, 16'h0000);
        sender_idle_pct = 65;
        add_random_frames(150);
        wait_idle();

        set_config(pbssl_pkg::RST_BEACON_TYPE, 32'd100, 16'd1000);
        sender_idle_pct = 0;
        add_random_frames(250);
        wait_idle();

        set_config(16'($urandom()), pbssl_pkg::RST_INTERVAL, pbssl_pkg::RST_CEILING);
        sender_idle_pct = 26;
        add_random_frames(240);
        wait_idle();

        if (mismatches == 0) begin
            $display("per_beam_signal_strength_logger_unit test passed");
        end else begin
            $display("per_beam_signal_strength_logger_unit test failed");
        end
        $finish;
    end

endmodule
